@@ hw/rtl/kts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kts_pkg;

    localparam logic [32:0] MAX_SOURCE_BYTES = 33'd16777216;
    localparam int KEYWORD_CHARS = 9;
    localparam int KW_LEN_MAX = 9;
    localparam int KW_COUNT = 64;

    // scanner modes
    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_CMT  = 4'd1;
    localparam logic [3:0] M_EQ   = 4'd2;
    localparam logic [3:0] M_LT   = 4'd3;
    localparam logic [3:0] M_GT   = 4'd4;
    localparam logic [3:0] M_INT  = 4'd5;
    localparam logic [3:0] M_DOTP = 4'd6;
    localparam logic [3:0] M_FRAC = 4'd7;
    localparam logic [3:0] M_EXPM = 4'd8;
    localparam logic [3:0] M_EXPS = 4'd9;
    localparam logic [3:0] M_EXPD = 4'd10;
    localparam logic [3:0] M_STR  = 4'd11;
    localparam logic [3:0] M_WORD = 4'd12;

    // token kinds
    localparam logic [6:0] K_LPAREN  = 7'd0;
    localparam logic [6:0] K_RPAREN  = 7'd1;
    localparam logic [6:0] K_LBRACE  = 7'd2;
    localparam logic [6:0] K_RBRACE  = 7'd3;
    localparam logic [6:0] K_LBRACK  = 7'd4;
    localparam logic [6:0] K_RBRACK  = 7'd5;
    localparam logic [6:0] K_COMMA   = 7'd6;
    localparam logic [6:0] K_DOT     = 7'd7;
    localparam logic [6:0] K_COLON   = 7'd8;
    localparam logic [6:0] K_PLUS    = 7'd9;
    localparam logic [6:0] K_MINUS   = 7'd10;
    localparam logic [6:0] K_STAR    = 7'd11;
    localparam logic [6:0] K_SLASH   = 7'd12;
    localparam logic [6:0] K_PERCENT = 7'd13;
    localparam logic [6:0] K_DOLLAR  = 7'd14;
    localparam logic [6:0] K_HASH    = 7'd15;
    localparam logic [6:0] K_ASSIGN  = 7'd16;
    localparam logic [6:0] K_EQ2     = 7'd17;
    localparam logic [6:0] K_LT      = 7'd18;
    localparam logic [6:0] K_LE      = 7'd19;
    localparam logic [6:0] K_NE      = 7'd20;
    localparam logic [6:0] K_GT      = 7'd21;
    localparam logic [6:0] K_GE      = 7'd22;
    localparam logic [6:0] K_NL      = 7'd23;
    localparam logic [6:0] K_NUM     = 7'd24;
    localparam logic [6:0] K_STR     = 7'd25;
    localparam logic [6:0] K_IDENT   = 7'd26;
    localparam logic [6:0] K_ERR     = 7'd27;
    localparam logic [6:0] K_EOF     = 7'd28;
    localparam logic [6:0] K_KEYBASE = 7'd29;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_CHAR    = 2'd1;
    localparam logic [1:0] E_EXP     = 2'd2;
    localparam logic [1:0] E_STRING  = 2'd3;

    localparam logic [19:0] LINE_TOP = 20'hFFFFF;

    // keywords, right-justified and zero-padded
    localparam logic [8*KW_LEN_MAX-1:0] KW_TABLE [KW_COUNT] = '{
        "DEF", "END", "DEFDAT", "ENDDAT", "PUBLIC", "GLOBAL",
        "DECL", "CONST", "STRUC", "ENUM",
        "INT", "REAL", "BOOL", "CHAR", "FRAME", "POS", "E6POS", "E6AXIS", "AXIS",
        "IF", "THEN", "ELSE", "ENDIF", "FOR", "TO", "STEP", "ENDFOR", "WHILE",
        "ENDWHILE", "LOOP", "ENDLOOP", "REPEAT", "UNTIL", "SWITCH", "CASE",
        "DEFAULT", "ENDSWITCH",
        "GOTO", "HALT", "CONTINUE", "EXIT", "WAIT", "SEC",
        "TRUE", "FALSE",
        "PTP", "LIN", "CIRC", "PTP_REL", "LIN_REL", {"CIRC", "_REL"}, "HOME",
        "C_PTP", "C_DIS", "C_VEL", "C_ORI",
        "AND", "OR", "NOT", "EXOR",
        "B_AND", "B_OR", "B_NOT", "B_EXOR"
    };

    typedef struct packed {
        logic [6:0]  kind;
        logic [23:0] start;
        logic [24:0] length;
        logic [19:0] line;
        logic [24:0] column;
        logic [1:0]  err;
        logic        last;
    } tok_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/keyword_token_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A token caused by a byte enters the four-entry output queue as the byte is taken.
// Throughput, while m_ready is high: one byte per cycle while each byte yields at most
// one token; a byte yielding two or three tokens is drained one token per cycle.
// s_ready is high while the queue holds at most one token.
// Reset (aresetn low, synchronous): empty queue, idle scanner, offset 0, line 1.
module keyword_token_scanner #(
    parameter logic [32:0] MAX_SOURCE_BYTES = kts_pkg::MAX_SOURCE_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_source_byte,
    input  wire logic        s_end_marker,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [6:0]       m_token_kind,
    output logic [23:0]      m_token_start,
    output logic [24:0]      m_token_length,
    output logic [19:0]      m_line_number,
    output logic [24:0]      m_column_number,
    output logic [1:0]       m_error_code,
    output logic             m_last_of_run
);

    localparam int WL_W = $clog2(kts_pkg::KEYWORD_CHARS + 2);
    localparam int WV_W = 8 * kts_pkg::KW_LEN_MAX;

    logic [3:0]      mode_reg, mode_next;
    logic [WV_W-1:0] wvec_reg, wvec_next;
    logic [WL_W-1:0] wlen_reg, wlen_next;
    logic [23:0]     start_reg, start_next;
    logic [23:0]     cur_reg, cur_next;
    logic [19:0]     line_reg, line_next;
    logic [24:0]     nl_reg, nl_next;
    logic [24:0]     scol_reg, scol_next;

    kts_pkg::tok_t   q_reg [4];
    kts_pkg::tok_t   q_next [4];
    logic [2:0]      cnt_reg, cnt_next;

    kts_pkg::tok_t   tok [3];
    logic [1:0]      ntok;

    logic accept, pop, cap_full, again, close_do, fresh_do;
    logic cont_v, c0_v, c1_v, f_v;
    kts_pkg::tok_t cont_t, c0_t, c1_t, f_t, eof_t;
    logic [24:0] len_cur, pos25, fcol;
    logic [7:0]  c, uc;
    logic        kw_hit;
    logic [5:0]  kw_idx;
    logic [6:0]  wkind;

    assign s_ready  = (cnt_reg <= 3'd1);
    assign accept   = s_valid && s_ready;
    assign m_valid  = (cnt_reg != 3'd0);
    assign pop      = m_valid && m_ready;
    assign cap_full = ({9'd0, cur_reg} >= (MAX_SOURCE_BYTES - 33'd1));
    assign c        = s_source_byte;
    assign uc       = kts_pkg::upcase(c);
    assign pos25    = {1'b0, cur_reg};
    assign len_cur  = pos25 - {1'b0, start_reg};
    assign fcol     = pos25 - nl_reg;

    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int i = 0; i < kts_pkg::KW_COUNT; i++) begin
            if (!kw_hit && wvec_reg == kts_pkg::KW_TABLE[i]) begin
                kw_hit = 1'b1;
                kw_idx = 6'(i);
            end
        end
        if (wlen_reg > WL_W'(kts_pkg::KW_LEN_MAX)) kw_hit = 1'b0;
        wkind = kw_hit ? kts_pkg::K_KEYBASE + {1'b0, kw_idx} : kts_pkg::K_IDENT;
    end

    function automatic kts_pkg::tok_t mk(input logic [6:0] k, input logic [23:0] s,
                                         input logic [24:0] l, input logic [19:0] ln,
                                         input logic [24:0] col, input logic [1:0] e);
        kts_pkg::tok_t t;
        t.kind = k; t.start = s; t.length = l; t.line = ln;
        t.column = col; t.err = e; t.last = 1'b0;
        return t;
    endfunction

    always_comb begin
        mode_next  = mode_reg;
        wvec_next  = wvec_reg;
        wlen_next  = wlen_reg;
        start_next = start_reg;
        cur_next   = cur_reg;
        line_next  = line_reg;
        nl_next    = nl_reg;
        scol_next  = scol_reg;
        again  = 1'b0;
        cont_v = 1'b0;
        cont_t = mk(kts_pkg::K_NUM, start_reg, 25'd2, line_reg, scol_reg, kts_pkg::E_NONE);
        close_do = 1'b0;
        fresh_do = 1'b0;

        if (accept && s_end_marker) begin
            close_do = 1'b1;
        end else if (accept && !cap_full) begin
            cur_next = cur_reg + 24'd1;
            unique case (mode_reg)
                kts_pkg::M_CMT: if (c == "\n") again = 1'b1;
                kts_pkg::M_STR: begin
                    if (c == "\"") begin
                        cont_v = 1'b1;
                        cont_t = mk(kts_pkg::K_STR, start_reg, len_cur + 25'd1, line_reg,
                                    scol_reg, kts_pkg::E_NONE);
                        mode_next = kts_pkg::M_IDLE;
                    end else if (c == "\n") begin
                        if (line_reg < kts_pkg::LINE_TOP) line_next = line_reg + 20'd1;
                        nl_next = pos25;
                    end
                end
                kts_pkg::M_EQ: begin
                    if (c == "=") begin
                        cont_v = 1'b1; cont_t.kind = kts_pkg::K_EQ2;
                        mode_next = kts_pkg::M_IDLE;
                    end else again = 1'b1;
                end
                kts_pkg::M_LT: begin
                    if (c == "=" || c == ">") begin
                        cont_v = 1'b1;
                        cont_t.kind = (c == "=") ? kts_pkg::K_LE : kts_pkg::K_NE;
                        mode_next = kts_pkg::M_IDLE;
                    end else again = 1'b1;
                end
                kts_pkg::M_GT: begin
                    if (c == "=") begin
                        cont_v = 1'b1; cont_t.kind = kts_pkg::K_GE;
                        mode_next = kts_pkg::M_IDLE;
                    end else again = 1'b1;
                end
                kts_pkg::M_INT: begin
                    if (kts_pkg::is_digit(c)) ;
                    else if (c == ".") mode_next = kts_pkg::M_DOTP;
                    else if (uc == "E") mode_next = kts_pkg::M_EXPM;
                    else again = 1'b1;
                end
                kts_pkg::M_DOTP: begin
                    if (kts_pkg::is_digit(c)) mode_next = kts_pkg::M_FRAC;
                    else again = 1'b1;
                end
                kts_pkg::M_FRAC: begin
                    if (kts_pkg::is_digit(c)) ;
                    else if (uc == "E") mode_next = kts_pkg::M_EXPM;
                    else again = 1'b1;
                end
                kts_pkg::M_EXPM: begin
                    if (c == "+" || c == "-") mode_next = kts_pkg::M_EXPS;
                    else if (kts_pkg::is_digit(c)) mode_next = kts_pkg::M_EXPD;
                    else again = 1'b1;
                end
                kts_pkg::M_EXPS: begin
                    if (kts_pkg::is_digit(c)) mode_next = kts_pkg::M_EXPD;
                    else again = 1'b1;
                end
                kts_pkg::M_EXPD: if (!kts_pkg::is_digit(c)) again = 1'b1;
                kts_pkg::M_WORD: begin
                    if (kts_pkg::is_alpha(c) || kts_pkg::is_digit(c) || c == "_") begin
                        if (wlen_reg < WL_W'(kts_pkg::KEYWORD_CHARS))
                            wvec_next = {wvec_reg[WV_W-9:0], uc};
                        if (wlen_reg <= WL_W'(kts_pkg::KEYWORD_CHARS))
                            wlen_next = wlen_reg + 1'b1;
                    end else again = 1'b1;
                end
                default: fresh_do = 1'b1;
            endcase
            if (again) begin
                close_do = 1'b1;
                fresh_do = 1'b1;
            end
        end

        // pending token closed just before the current byte
        c0_v = close_do;
        c1_v = 1'b0;
        c0_t = mk(kts_pkg::K_NUM, start_reg, len_cur, line_reg, scol_reg, kts_pkg::E_NONE);
        c1_t = mk(kts_pkg::K_DOT, cur_reg - 24'd1, 25'd1, line_reg,
                  scol_reg + len_cur - 25'd1, kts_pkg::E_NONE);
        unique case (mode_reg)
            kts_pkg::M_EQ: begin c0_t.kind = kts_pkg::K_ASSIGN; c0_t.length = 25'd1; end
            kts_pkg::M_LT: begin c0_t.kind = kts_pkg::K_LT; c0_t.length = 25'd1; end
            kts_pkg::M_GT: begin c0_t.kind = kts_pkg::K_GT; c0_t.length = 25'd1; end
            kts_pkg::M_INT, kts_pkg::M_FRAC, kts_pkg::M_EXPD: ;
            kts_pkg::M_DOTP: begin
                c0_t.length = len_cur - 25'd1;
                c1_v = close_do;
            end
            kts_pkg::M_EXPM, kts_pkg::M_EXPS: begin
                c0_t.kind = kts_pkg::K_ERR; c0_t.err = kts_pkg::E_EXP;
            end
            kts_pkg::M_STR: begin
                c0_t.kind = kts_pkg::K_ERR; c0_t.err = kts_pkg::E_STRING;
            end
            kts_pkg::M_WORD: c0_t.kind = wkind;
            default: c0_v = 1'b0;
        endcase

        // current byte as the first byte of a new token
        f_v = 1'b0;
        f_t = mk(kts_pkg::K_ERR, cur_reg, 25'd1, line_reg, fcol, kts_pkg::E_NONE);
        if (fresh_do) begin
            start_next = cur_reg;
            scol_next  = fcol;
            mode_next  = kts_pkg::M_IDLE;
            unique case (c)
                "(": begin f_v = 1'b1; f_t.kind = kts_pkg::K_LPAREN;  end
                ")": begin f_v = 1'b1; f_t.kind = kts_pkg::K_RPAREN;  end
                "{": begin f_v = 1'b1; f_t.kind = kts_pkg::K_LBRACE;  end
                "}": begin f_v = 1'b1; f_t.kind = kts_pkg::K_RBRACE;  end
                "[": begin f_v = 1'b1; f_t.kind = kts_pkg::K_LBRACK;  end
                "]": begin f_v = 1'b1; f_t.kind = kts_pkg::K_RBRACK;  end
                ",": begin f_v = 1'b1; f_t.kind = kts_pkg::K_COMMA;   end
                ".": begin f_v = 1'b1; f_t.kind = kts_pkg::K_DOT;     end
                ":": begin f_v = 1'b1; f_t.kind = kts_pkg::K_COLON;   end
                "+": begin f_v = 1'b1; f_t.kind = kts_pkg::K_PLUS;    end
                "-": begin f_v = 1'b1; f_t.kind = kts_pkg::K_MINUS;   end
                "*": begin f_v = 1'b1; f_t.kind = kts_pkg::K_STAR;    end
                "/": begin f_v = 1'b1; f_t.kind = kts_pkg::K_SLASH;   end
                "%": begin f_v = 1'b1; f_t.kind = kts_pkg::K_PERCENT; end
                "$": begin f_v = 1'b1; f_t.kind = kts_pkg::K_DOLLAR;  end
                "#": begin f_v = 1'b1; f_t.kind = kts_pkg::K_HASH;    end
                "=":  mode_next = kts_pkg::M_EQ;
                "<":  mode_next = kts_pkg::M_LT;
                ">":  mode_next = kts_pkg::M_GT;
                ";":  mode_next = kts_pkg::M_CMT;
                "\"": mode_next = kts_pkg::M_STR;
                "\n": begin
                    f_v = 1'b1;
                    f_t.kind = kts_pkg::K_NL;
                    f_t.column = '0;
                    if (line_reg < kts_pkg::LINE_TOP) line_next = line_reg + 20'd1;
                    nl_next = pos25;
                end
                " ", 8'h0D, "\t": ;
                default: begin
                    if (kts_pkg::is_digit(c)) begin
                        mode_next = kts_pkg::M_INT;
                    end else if (kts_pkg::is_alpha(c) || c == "_") begin
                        mode_next = kts_pkg::M_WORD;
                        wvec_next = {{(WV_W-8){1'b0}}, uc};
                        wlen_next = WL_W'(1);
                    end else begin
                        f_v = 1'b1;
                        f_t.err = kts_pkg::E_CHAR;
                    end
                end
            endcase
        end

        eof_t = mk(kts_pkg::K_EOF, cur_reg, 25'd0, line_reg, fcol, kts_pkg::E_NONE);

        ntok = '0;
        for (int i = 0; i < 3; i++) tok[i] = eof_t;
        if (cont_v) begin tok[ntok] = cont_t; ntok = ntok + 2'd1; end
        if (c0_v)   begin tok[ntok] = c0_t;   ntok = ntok + 2'd1; end
        if (c1_v)   begin tok[ntok] = c1_t;   ntok = ntok + 2'd1; end
        if (f_v)    begin tok[ntok] = f_t;    ntok = ntok + 2'd1; end
        if (accept && s_end_marker) begin
            tok[ntok] = eof_t;
            ntok = ntok + 2'd1;
            mode_next  = kts_pkg::M_IDLE;
            wvec_next  = '0;
            wlen_next  = '0;
            start_next = '0;
            cur_next   = '0;
            line_next  = 20'd1;
            nl_next    = '1;
            scol_next  = '0;
        end
        if (ntok != 2'd0) tok[ntok - 2'd1].last = 1'b1;
    end

    // output queue: head at entry 0, shifts on each token taken
    always_comb begin
        logic [2:0] base;
        for (int i = 0; i < 4; i++) q_next[i] = q_reg[i];
        base = cnt_reg;
        if (pop) begin
            for (int i = 0; i < 3; i++) q_next[i] = q_reg[i+1];
            base = cnt_reg - 3'd1;
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < ntok) q_next[2'(base + 3'(i))] = tok[i];
        end
        cnt_next = base + {1'b0, ntok};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= kts_pkg::M_IDLE;
            wvec_reg  <= '0;
            wlen_reg  <= '0;
            start_reg <= '0;
            cur_reg   <= '0;
            line_reg  <= 20'd1;
            nl_reg    <= '1;
            scol_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            wvec_reg  <= wvec_next;
            wlen_reg  <= wlen_next;
            start_reg <= start_next;
            cur_reg   <= cur_next;
            line_reg  <= line_next;
            nl_reg    <= nl_next;
            scol_reg  <= scol_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) q_reg[i] <= q_next[i];
    end

    assign m_token_kind    = q_reg[0].kind;
    assign m_token_start   = q_reg[0].start;
    assign m_token_length  = q_reg[0].length;
    assign m_line_number   = q_reg[0].line;
    assign m_column_number = q_reg[0].column;
    assign m_error_code    = q_reg[0].err;
    assign m_last_of_run   = q_reg[0].last;

endmodule

`default_nettype wire

@@ tb/keyword_token_scanner_tb.sv @@
`timescale 1ns / 1ps

module keyword_token_scanner_tb;

    typedef struct {
        logic [7:0] ch;
        logic       eof;
    } src_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_source_byte = 8'd0;
    logic        s_end_marker = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_token_kind;
    logic [23:0] m_token_start;
    logic [24:0] m_token_length;
    logic [19:0] m_line_number;
    logic [24:0] m_column_number;
    logic [1:0]  m_error_code;
    logic        m_last_of_run;

    keyword_token_scanner dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_source_byte(s_source_byte), .s_end_marker(s_end_marker),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_token_kind(m_token_kind), .m_token_start(m_token_start),
        .m_token_length(m_token_length), .m_line_number(m_line_number),
        .m_column_number(m_column_number), .m_error_code(m_error_code),
        .m_last_of_run(m_last_of_run)
    );

    always #2 aclk = ~aclk;

    // predictor state
    logic [3:0]  lx_mode;
    logic [7:0]  lx_word [kts_pkg::KEYWORD_CHARS];
    int unsigned lx_wlen;
    longint      lx_start, lx_pos, lx_nl, lx_col;
    logic [19:0] lx_line;

    kts_pkg::tok_t token_q[$];
    src_req_t      pending_q[$];
    kts_pkg::tok_t step_toks[$];
    int       hold_for_drain = 0;   // driver waits here until expected tokens are out
    int       errors = 0;
    int       n_tokens = 0;
    int       n_reqs = 0;
    int       idle_cycles = 0;
    int       drain_pauses = 0;
    logic     in_acc = 1'b0;        // request taken at the last rising edge

    function automatic void lx_reset();
        lx_mode = kts_pkg::M_IDLE;
        foreach (lx_word[i]) lx_word[i] = 8'd0;
        lx_wlen = 0;
        lx_start = 0;
        lx_pos = 0;
        lx_nl = -1;
        lx_col = 0;
        lx_line = 20'd1;
    endfunction

    function automatic void put_tok(logic [6:0] k, longint st, longint len, longint col,
                                    logic [1:0] e);
        kts_pkg::tok_t t;
        t.kind = k;
        t.start = st[23:0];
        t.length = len[24:0];
        t.line = lx_line;
        t.column = col[24:0];
        t.err = e;
        t.last = 1'b0;
        if (step_toks.size() < 3) step_toks = {step_toks, t};
    endfunction

    function automatic logic [6:0] keyword_kind();
        logic [8*kts_pkg::KW_LEN_MAX-1:0] w;
        w = '0;
        if (lx_wlen > kts_pkg::KEYWORD_CHARS) return kts_pkg::K_IDENT;
        for (int i = 0; i < lx_wlen; i++) w = {w[8*kts_pkg::KW_LEN_MAX-9:0], lx_word[i]};
        for (int i = 0; i < kts_pkg::KW_COUNT; i++)
            if (kts_pkg::KW_TABLE[i] == w) return kts_pkg::K_KEYBASE + 7'(i);
        return kts_pkg::K_IDENT;
    endfunction

    function automatic void flush_pending(longint p);
        longint len;
        len = p - lx_start;
        case (lx_mode)
            kts_pkg::M_EQ: put_tok(kts_pkg::K_ASSIGN, lx_start, 1, lx_col, kts_pkg::E_NONE);
            kts_pkg::M_LT: put_tok(kts_pkg::K_LT, lx_start, 1, lx_col, kts_pkg::E_NONE);
            kts_pkg::M_GT: put_tok(kts_pkg::K_GT, lx_start, 1, lx_col, kts_pkg::E_NONE);
            kts_pkg::M_INT, kts_pkg::M_FRAC, kts_pkg::M_EXPD:
                put_tok(kts_pkg::K_NUM, lx_start, len, lx_col, kts_pkg::E_NONE);
            kts_pkg::M_DOTP: begin
                put_tok(kts_pkg::K_NUM, lx_start, len - 1, lx_col, kts_pkg::E_NONE);
                put_tok(kts_pkg::K_DOT, p - 1, 1, lx_col + len - 1, kts_pkg::E_NONE);
            end
            kts_pkg::M_EXPM, kts_pkg::M_EXPS:
                put_tok(kts_pkg::K_ERR, lx_start, len, lx_col, kts_pkg::E_EXP);
            kts_pkg::M_STR: put_tok(kts_pkg::K_ERR, lx_start, len, lx_col, kts_pkg::E_STRING);
            kts_pkg::M_WORD: put_tok(keyword_kind(), lx_start, len, lx_col, kts_pkg::E_NONE);
            default: ;
        endcase
        lx_mode = kts_pkg::M_IDLE;
    endfunction

    function automatic void begin_token(logic [7:0] c, longint p);
        string singles;
        singles = "(){}[],.:+-*/%$#";
        lx_start = p;
        lx_col = p - lx_nl;
        lx_mode = kts_pkg::M_IDLE;
        for (int i = 0; i < 16; i++)
            if (c == singles[i]) begin
                put_tok(7'(i), lx_start, 1, lx_col, kts_pkg::E_NONE);
                return;
            end
        if (c == "=") lx_mode = kts_pkg::M_EQ;
        else if (c == "<") lx_mode = kts_pkg::M_LT;
        else if (c == ">") lx_mode = kts_pkg::M_GT;
        else if (c == ";") lx_mode = kts_pkg::M_CMT;
        else if (c == "\"") lx_mode = kts_pkg::M_STR;
        else if (c == 8'h0A) begin
            put_tok(kts_pkg::K_NL, p, 1, 0, kts_pkg::E_NONE);
            if (lx_line != kts_pkg::LINE_TOP) lx_line++;
            lx_nl = p;
        end else if (c == " " || c == 8'h0D || c == 8'h09) begin
        end else if (kts_pkg::is_digit(c)) lx_mode = kts_pkg::M_INT;
        else if (kts_pkg::is_alpha(c) || c == "_") begin
            lx_mode = kts_pkg::M_WORD;
            lx_word[0] = kts_pkg::upcase(c);
            lx_wlen = 1;
        end else put_tok(kts_pkg::K_ERR, p, 1, lx_col, kts_pkg::E_CHAR);
    endfunction

    function automatic void predict_tokens(src_req_t r);
        logic [7:0] c;
        longint p;
        logic rescan;
        c = r.ch;
        p = lx_pos;
        rescan = 1'b0;
        step_toks.delete();
        if (r.eof) begin
            flush_pending(p);
            put_tok(kts_pkg::K_EOF, p, 0, p - lx_nl, kts_pkg::E_NONE);
            lx_reset();
        end else if (p < longint'(kts_pkg::MAX_SOURCE_BYTES) - 1) begin
            case (lx_mode)
                kts_pkg::M_CMT: if (c == 8'h0A) rescan = 1'b1;
                kts_pkg::M_STR: begin
                    if (c == "\"") begin
                        put_tok(kts_pkg::K_STR, lx_start, p + 1 - lx_start, lx_col,
                                kts_pkg::E_NONE);
                        lx_mode = kts_pkg::M_IDLE;
                    end else if (c == 8'h0A) begin
                        if (lx_line != kts_pkg::LINE_TOP) lx_line++;
                        lx_nl = p;
                    end
                end
                kts_pkg::M_EQ: begin
                    if (c == "=") begin
                        put_tok(kts_pkg::K_EQ2, lx_start, 2, lx_col, kts_pkg::E_NONE);
                        lx_mode = kts_pkg::M_IDLE;
                    end else rescan = 1'b1;
                end
                kts_pkg::M_LT: begin
                    if (c == "=" || c == ">") begin
                        put_tok(c == "=" ? kts_pkg::K_LE : kts_pkg::K_NE, lx_start, 2,
                                lx_col, kts_pkg::E_NONE);
                        lx_mode = kts_pkg::M_IDLE;
                    end else rescan = 1'b1;
                end
                kts_pkg::M_GT: begin
                    if (c == "=") begin
                        put_tok(kts_pkg::K_GE, lx_start, 2, lx_col, kts_pkg::E_NONE);
                        lx_mode = kts_pkg::M_IDLE;
                    end else rescan = 1'b1;
                end
                kts_pkg::M_INT: begin
                    if (c == ".") lx_mode = kts_pkg::M_DOTP;
                    else if (c == "E" || c == "e") lx_mode = kts_pkg::M_EXPM;
                    else if (!kts_pkg::is_digit(c)) rescan = 1'b1;
                end
                kts_pkg::M_DOTP:
                    if (kts_pkg::is_digit(c)) lx_mode = kts_pkg::M_FRAC; else rescan = 1'b1;
                kts_pkg::M_FRAC: begin
                    if (c == "E" || c == "e") lx_mode = kts_pkg::M_EXPM;
                    else if (!kts_pkg::is_digit(c)) rescan = 1'b1;
                end
                kts_pkg::M_EXPM: begin
                    if (c == "+" || c == "-") lx_mode = kts_pkg::M_EXPS;
                    else if (kts_pkg::is_digit(c)) lx_mode = kts_pkg::M_EXPD;
                    else rescan = 1'b1;
                end
                kts_pkg::M_EXPS:
                    if (kts_pkg::is_digit(c)) lx_mode = kts_pkg::M_EXPD; else rescan = 1'b1;
                kts_pkg::M_EXPD: if (!kts_pkg::is_digit(c)) rescan = 1'b1;
                kts_pkg::M_WORD: begin
                    if (kts_pkg::is_alpha(c) || kts_pkg::is_digit(c) || c == "_") begin
                        if (lx_wlen < kts_pkg::KEYWORD_CHARS)
                            lx_word[lx_wlen] = kts_pkg::upcase(c);
                        if (lx_wlen <= kts_pkg::KEYWORD_CHARS) lx_wlen++;
                    end else rescan = 1'b1;
                end
                default: begin_token(c, p);
            endcase
            if (rescan) begin
                flush_pending(p);
                begin_token(c, p);
            end
            lx_pos = p + 1;
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) token_q = {token_q, step_toks[i]};
    endfunction

    // driver: bursts and gaps, one drain pause at a marked point
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !in_acc) begin
                // hold request
            end else if (hold_for_drain > 0 && pending_q.size() == hold_for_drain) begin
                s_valid <= 1'b0;
                if (token_q.size() == 0) begin
                    hold_for_drain = 0;
                    drain_pauses++;
                end
            end else if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left--;
            end else if (pending_q.size() > 0) begin
                s_valid <= 1'b1;
                s_source_byte <= pending_q[0].ch;
                s_end_marker <= pending_q[0].eof;
                void'(pending_q.pop_front());
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                end else burst_left--;
            end else s_valid <= 1'b0;
            // receiver stall pattern: long ready stretches and occasional stall runs
            m_ready <= ($urandom_range(0, 15) < 11) || (lx_pos % 64 < 16);
        end
    end

    // monitor: prediction at input acceptance, comparison at output acceptance
    always @(posedge aclk) begin
        kts_pkg::tok_t got, exp_t;
        in_acc = s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                src_req_t r;
                r.ch = s_source_byte;
                r.eof = s_end_marker;
                predict_tokens(r);
                n_reqs++;
            end
            if (m_valid && m_ready) begin
                got = '{m_token_kind, m_token_start, m_token_length, m_line_number,
                        m_column_number, m_error_code, m_last_of_run};
                n_tokens++;
                if (token_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected token, actual %p", $time, got);
                end else begin
                    exp_t = token_q.pop_front();
                    if (got !== exp_t) begin
                        errors++;
                        $display("%0t: token mismatch, expected %p actual %p",
                                 $time, exp_t, got);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    task automatic add_byte(logic [7:0] b);
        src_req_t r;
        r.ch = b;
        r.eof = 1'b0;
        pending_q = {pending_q, r};
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_eof();
        src_req_t r;
        r.ch = 8'($urandom());
        r.eof = 1'b1;
        pending_q = {pending_q, r};
    endtask

    task automatic add_random_text(int n);
        string frags [24];
        frags = '{"DEF ", "endswitch", "b_exor", "Ptp_Rel ", "x_9", "12.5e-3", "7E",
                  "3.", "3.x", "42 ", "\"hi\nthere\"", "; note\n", "==", "<>", "<=",
                  ">=", "<", ">", "=", "\n", "  \t\015", "(a,b)", "abcdefghijk ", "1e+"};
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                add_text(frags[$urandom_range(0, 23)]);
            end else begin
                add_byte(($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                     : 8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 40) == 0) add_eof();
        end
    endtask

    initial begin
        lx_reset();
        // directed: operators, numbers, special cases, keyword extremes
        add_text("(){}[],.:+-*/%$#=a==<b<=<>>c>=\n");
        add_text("Enddat endswitch ENDSWITCH9 LongIdentifier _x\n");
        add_text("0 9.25 1e5 2.5E+3 4.e 6E- 8.;c\n");
        add_eof();
        add_text("\"a\nb\" \"open\nstr");
        add_eof();
        add_text("a");
        add_byte(8'h80);
        add_text("1");
        add_byte(8'hFF);
        add_byte(8'h00);
        add_text("9");
        add_eof();
        add_eof();
        hold_for_drain = 0;
        add_random_text(18);
        hold_for_drain = pending_q.size() + 0;
        begin
            int keep;
            keep = pending_q.size();
            add_random_text(18);
            add_eof();
            hold_for_drain = pending_q.size() - keep;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        @(posedge aresetn);
        while (pending_q.size() > 0 || s_valid || token_q.size() > 0) begin
            @(posedge aclk);
            if (idle_cycles > 5000) begin
                $display("[keyword_token_scanner] ERROR");
                $finish;
            end
        end
        repeat (20) @(posedge aclk);
        $display("Scanned %0d source requests into %0d tokens, %0d drain pause(s).",
                 n_reqs, n_tokens, drain_pauses);
        if (errors == 0 && token_q.size() == 0 && !m_valid) begin
            $display("[keyword_token_scanner] OK");
        end else begin
            $display("[keyword_token_scanner] ERROR");
        end
        $finish;
    end

endmodule
